>>> sv/drl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the decimating ring logger.
// No dependencies; the top level and the checker import this package.
package drl_pkg;

	localparam int DRL_DEPTH = 1024;

	localparam logic [10:0] RING_SIZE_RST       = 11'd1024;
	localparam logic [31:0] SAMPLE_INTERVAL_RST = 32'd6554;
	localparam logic [47:0] MIN_DIST_RST        = 48'd4295;
	localparam logic [32:0] TIME_MAX            = '1;

	typedef enum logic [1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_FLUSH  = 2'd1,
		KIND_CLEAR  = 2'd2,
		KIND_READ   = 2'd3
	} drl_kind_t;

	typedef enum logic [1:0] {
		REG_RING_SIZE       = 2'd0,
		REG_SAMPLE_INTERVAL = 2'd1,
		REG_MIN_DIST        = 2'd2,
		REG_HOLD            = 2'd3
	} drl_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LAST,
		S_DIST,
		S_CHECK,
		S_FETCH,
		S_CLEAR
	} drl_state_t;

	typedef struct packed {
		drl_kind_t          kind;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic        [31:0] elapsed;
		logic        [9:0]  read_index;
	} drl_req_t;

	typedef struct packed {
		logic               stored;
		logic        [9:0]  write_index;
		logic        [10:0] fill_count;
		logic               dirty_pending;
		logic        [9:0]  range_start;
		logic        [10:0] range_len;
		logic        [10:0] wrap_len;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} drl_res_t;

endpackage

>>> sv/drl_ram.sv
`timescale 1ns / 1ps
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module drl_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/decimating_ring_logger_dirty_range_unit.sv
`timescale 1ns / 1ps
// Top level of the decimating ring logger with dirty-range tracking.
// Depends on drl_pkg and drl_ram.
//
//  channel   handshake                 payload
//  request   start in, busy out        req    (drl_req_t)
//  result    done out (one-cycle pulse) result (drl_res_t)
//  config    cfg_valid in, cfg_ready   cfg_index, cfg_data
//
// A sample that passes the timer with hold off and points in the ring goes
// through the read of the last point (S_LAST), the S_DIST steps through the
// one shared 32x32 squarer, and the compare and write (S_CHECK). Every other
// sample and every flush is answered from S_IDLE; a read adds S_FETCH for the
// memory read. A clear item, and reset, sweep the point memory in S_CLEAR one
// entry per cycle with busy high. The result is registered from the state that
// makes it (a clear answers on accept, before the sweep); it cannot be stalled.
module decimating_ring_logger_dirty_range_unit #(
	parameter int DEPTH = drl_pkg::DRL_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  drl_pkg::drl_req_t req,
	output logic              done,
	output drl_pkg::drl_res_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  drl_pkg::drl_reg_t cfg_index,
	input  logic [47:0]       cfg_data
);
	import drl_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST_ENTRY = AW'(DEPTH - 1);
	localparam logic [1:0] COORD_LAST = 2'd3;

	drl_state_t state_q, state_d;

	logic [10:0] ring_size_q;
	logic [31:0] interval_q;
	logic [47:0] min_dist_q;
	logic        hold_q;

	logic [AW-1:0] head_q, head_d;
	logic [10:0]   count_q, count_d;
	logic [32:0]   time_q, time_d;
	logic          dflag_q, dflag_d;
	logic [AW-1:0] dfirst_q, dfirst_d;
	logic [AW:0]   dstop_q, dstop_d;
	logic          dwrap_q, dwrap_d;
	logic [1:0]    coord_q, coord_d;
	logic [AW-1:0] clr_q, clr_d;
	logic          done_q;

	logic [95:0] pos_q;
	logic        oor_q;
	logic [31:0] mag_q, mag_d;
	logic [63:0] sum_q, sum_d;
	drl_res_t    result_q, res_d;
	logic        res_valid;

	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [95:0]   ram_wdata, ram_rdata;

	logic          accept;
	logic [10:0]   size;
	logic [33:0]   acc_sum;
	logic [32:0]   acc_sat, acc_rem;
	logic          pass;
	logic [31:0]   last32, ri32, head_n32, flush_first, flush_stop, flush_size;
	logic [31:0]   rlen32, wlen32, headout32;
	logic [AW:0]   next_stop;
	logic          do_store;
	logic [95:0]   store_pt;
	logic [31:0]   coord_a, coord_b;
	logic signed [32:0] dif, dif_abs;
	logic [63:0]   prod;
	logic [64:0]   sum_wide;

	assign accept    = start && (state_q == S_IDLE);
	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign result    = result_q;
	assign cfg_ready = 1'b1;

	// Effective ring size: at least one entry and never beyond the memory.
	always_comb begin
		if (ring_size_q == 11'd0) begin
			size = 11'd1;
		end else if (32'(ring_size_q) > 32'(DEPTH)) begin
			size = 11'(DEPTH);
		end else begin
			size = ring_size_q;
		end
	end

	always_comb begin
		acc_sum = 34'(time_q) + 34'(req.elapsed);
		acc_sat = acc_sum[33] ? TIME_MAX : acc_sum[32:0];
		pass    = (acc_sat >= 33'(interval_q));
		acc_rem = acc_sat - 33'(interval_q);
		last32  = (head_q == '0) ? 32'(size) - 32'd1 : 32'(head_q) - 32'd1;
		ri32    = 32'(req.read_index);
		store_pt = (state_q == S_IDLE) ? {req.pos_x, req.pos_y, req.pos_z} : pos_q;
	end

	// One coordinate a cycle: the difference magnitude is registered, then
	// squared and added with saturation on the next cycle.
	always_comb begin
		case (coord_q)
			2'd0: begin
				coord_a = pos_q[95:64];
				coord_b = ram_rdata[95:64];
			end
			2'd1: begin
				coord_a = pos_q[63:32];
				coord_b = ram_rdata[63:32];
			end
			default: begin
				coord_a = pos_q[31:0];
				coord_b = ram_rdata[31:0];
			end
		endcase
		dif      = $signed({coord_a[31], coord_a}) - $signed({coord_b[31], coord_b});
		dif_abs  = dif[32] ? -dif : dif;
		prod     = mag_q * mag_q;
		sum_wide = {1'b0, sum_q} + {1'b0, prod};
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (req.kind)
						KIND_SAMPLE: begin
							if (!hold_q && pass && count_q != 11'd0) begin
								state_d = S_LAST;
							end
						end
						KIND_CLEAR: state_d = S_CLEAR;
						KIND_READ:  state_d = S_FETCH;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_LAST:  state_d = S_DIST;
			S_DIST: begin
				if (coord_q == COORD_LAST) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: state_d = S_IDLE;
			S_FETCH: state_d = S_IDLE;
			S_CLEAR: begin
				if (clr_q == LAST_ENTRY) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		head_d    = head_q;
		count_d   = count_q;
		time_d    = time_q;
		dflag_d   = dflag_q;
		dfirst_d  = dfirst_q;
		dstop_d   = dstop_q;
		dwrap_d   = dwrap_q;
		coord_d   = coord_q;
		clr_d     = clr_q;
		mag_d     = mag_q;
		sum_d     = sum_q;
		ram_we    = 1'b0;
		ram_waddr = head_q;
		ram_wdata = store_pt;
		ram_re    = 1'b0;
		ram_raddr = last32[AW-1:0];
		res_valid = 1'b0;
		res_d     = '0;
		do_store  = 1'b0;
		flush_first = 32'(dfirst_q);
		flush_stop  = 32'(dstop_q);
		flush_size  = 32'(size);
		rlen32    = '0;
		wlen32    = '0;
		head_n32  = 32'(head_q) + 32'd1;
		next_stop = (AW+1)'(head_q) + 1'b1;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (req.kind)
						KIND_SAMPLE: begin
							res_valid = 1'b1;
							if (!hold_q) begin
								time_d = pass ? acc_rem : acc_sat;
								if (pass) begin
									if (count_q == 11'd0) begin
										do_store = 1'b1;
									end else begin
										ram_re    = 1'b1;
										res_valid = 1'b0;
									end
								end
							end
						end
						KIND_FLUSH: begin
							res_valid = 1'b1;
							if (dflag_q) begin
								if (!dwrap_q) begin
									if (flush_stop > flush_first) begin
										rlen32 = flush_stop - flush_first;
									end
								end else begin
									if (flush_first < flush_size) begin
										rlen32 = flush_size - flush_first;
									end
									wlen32 = (flush_stop < flush_size) ? flush_stop : flush_size;
								end
								res_d.dirty_pending = 1'b1;
								res_d.range_start   = flush_first[9:0];
								res_d.range_len     = rlen32[10:0];
								res_d.wrap_len      = wlen32[10:0];
							end
							dflag_d  = 1'b0;
							dfirst_d = '0;
							dstop_d  = '0;
							dwrap_d  = 1'b0;
						end
						KIND_CLEAR: begin
							res_valid = 1'b1;
							head_d    = '0;
							count_d   = '0;
							time_d    = '0;
							clr_d     = '0;
						end
						KIND_READ: begin
							ram_re    = 1'b1;
							ram_raddr = ri32[AW-1:0];
						end
						default: res_valid = 1'b0;
					endcase
				end
			end
			S_LAST: begin
				sum_d   = '0;
				coord_d = 2'd0;
			end
			S_DIST: begin
				mag_d   = dif_abs[31:0];
				coord_d = coord_q + 2'd1;
				if (coord_q != 2'd0) begin
					sum_d = sum_wide[64] ? '1 : sum_wide[63:0];
				end
			end
			S_CHECK: begin
				res_valid = 1'b1;
				do_store  = (sum_q >= {16'd0, min_dist_q});
			end
			S_FETCH: begin
				res_valid = 1'b1;
				if (!oor_q) begin
					res_d.point_x = ram_rdata[95:64];
					res_d.point_y = ram_rdata[63:32];
					res_d.point_z = ram_rdata[31:0];
				end
			end
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				clr_d     = clr_q + 1'b1;
			end
			default: res_valid = 1'b0;
		endcase

		if (do_store) begin
			ram_we  = 1'b1;
			head_d  = (head_n32 >= 32'(size)) ? '0 : head_n32[AW-1:0];
			if (count_q < size) begin
				count_d = count_q + 11'd1;
			end
			if (!dflag_q) begin
				dflag_d  = 1'b1;
				dfirst_d = head_q;
				dwrap_d  = 1'b0;
			end else if (next_stop <= {1'b0, dfirst_q}) begin
				dwrap_d = 1'b1;
			end
			dstop_d = next_stop;
		end

		headout32         = 32'(head_d);
		res_d.stored      = do_store;
		res_d.write_index = headout32[9:0];
		res_d.fill_count  = count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			head_q      <= '0;
			count_q     <= '0;
			time_q      <= '0;
			dflag_q     <= 1'b0;
			dfirst_q    <= '0;
			dstop_q     <= '0;
			dwrap_q     <= 1'b0;
			coord_q     <= '0;
			clr_q       <= '0;
			done_q      <= 1'b0;
			ring_size_q <= RING_SIZE_RST;
			interval_q  <= SAMPLE_INTERVAL_RST;
			min_dist_q  <= MIN_DIST_RST;
			hold_q      <= 1'b0;
		end else begin
			state_q  <= state_d;
			head_q   <= head_d;
			count_q  <= count_d;
			time_q   <= time_d;
			dflag_q  <= dflag_d;
			dfirst_q <= dfirst_d;
			dstop_q  <= dstop_d;
			dwrap_q  <= dwrap_d;
			coord_q  <= coord_d;
			clr_q    <= clr_d;
			done_q   <= res_valid;
			if (cfg_valid) begin
				case (cfg_index)
					REG_RING_SIZE:       ring_size_q <= cfg_data[10:0];
					REG_SAMPLE_INTERVAL: interval_q  <= cfg_data[31:0];
					REG_MIN_DIST:        min_dist_q  <= cfg_data;
					REG_HOLD:            hold_q      <= cfg_data[0];
					default:             hold_q      <= hold_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q <= {req.pos_x, req.pos_y, req.pos_z};
			oor_q <= (ri32 >= 32'(DEPTH));
		end
		mag_q <= mag_d;
		sum_q <= sum_d;
		if (res_valid) begin
			result_q <= res_d;
		end
	end

	drl_ram #(
		.WIDTH (96),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

>>> sv/drl_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the ring logger, bound to its top level.
// Depends on drl_pkg and decimating_ring_logger_dirty_range_unit.
module drl_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input drl_pkg::drl_req_t req,
	input logic              done,
	input drl_pkg::drl_res_t result,
	input logic              cfg_valid,
	input logic              cfg_ready,
	input drl_pkg::drl_reg_t cfg_index,
	input logic [47:0]       cfg_data
);
	import drl_pkg::*;

	// A flush request is answered on the very next cycle and never stores.
	a_flush_next: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.kind == KIND_FLUSH) |=> (done && !result.stored))
		else $error("flush request not answered on the next cycle");

	// A clear request reports an empty ring and then sweeps the memory.
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.kind == KIND_CLEAR) |=>
		(done && busy && result.fill_count == 11'd0 && result.write_index == 10'd0))
		else $error("clear request did not empty the ring");

	// Without a pending dirty range every span must be zero.
	a_clean_spans: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.dirty_pending) |->
		(result.range_start == 10'd0 && result.range_len == 11'd0 &&
		result.wrap_len == 11'd0))
		else $error("span reported without a dirty range");

	// A stored point always leaves at least one valid entry.
	a_store_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.stored) |-> (result.fill_count != 11'd0))
		else $error("point stored but fill count is zero");

endmodule

bind decimating_ring_logger_dirty_range_unit drl_checker u_drl_checker (.*);
